### design/pps_pkg.sv
`timescale 1ns / 1ps

package pps_pkg;

  localparam int unsigned TIME_BITS    = 16;
  localparam int unsigned PRIO_BITS    = 8;
  localparam int unsigned SLOT_FIELD_W = 4;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [PRIO_BITS-1:0] prio_t;

  localparam time_t TIME_MAX = {TIME_BITS{1'b1}};

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // one task table entry
  typedef struct packed {
    time_t arrival;
    time_t burst;
    time_t remaining;
    prio_t prio;
    time_t response;
    logic  started;
  } task_t;

endpackage

### design/pps_if.sv
`timescale 1ns / 1ps

interface pps_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [pps_pkg::SLOT_FIELD_W-1:0]    slot;
  pps_pkg::time_t                      arrival_time;
  pps_pkg::time_t                      burst_time;
  pps_pkg::prio_t                      priority_req;

  modport source (
    output valid, req_type, slot, arrival_time, burst_time, priority_req,
    input  ready
  );
  modport sink (
    input  valid, req_type, slot, arrival_time, burst_time, priority_req,
    output ready
  );
endinterface

interface pps_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                running_valid;
  logic [pps_pkg::SLOT_FIELD_W-1:0]    running_slot;
  pps_pkg::time_t                      tick_time;
  logic                                finished;
  pps_pkg::time_t                      completion_time;
  pps_pkg::time_t                      turnaround_time;
  pps_pkg::time_t                      waiting_time;
  pps_pkg::time_t                      response_time;
  logic                                all_done;
  logic                                time_overflow;

  modport source (
    output valid, running_valid, running_slot, tick_time, finished, completion_time,
           turnaround_time, waiting_time, response_time, all_done, time_overflow,
    input  ready
  );
  modport sink (
    input  valid, running_valid, running_slot, tick_time, finished, completion_time,
           turnaround_time, waiting_time, response_time, all_done, time_overflow,
    output ready
  );
endinterface

### design/preemptive_priority_scheduler.sv
`timescale 1ns / 1ps

// Channel  Dir  Modport          Word
// req_i    in   pps_req_if.sink  load a task into a slot, or advance time one tick
// rsp_o    out  pps_rsp_if.source one word per tick: task that ran, times, status
//
// A load writes the task memory and the slot flags.
// A tick runs through its steps up to the next accept: the accept, then
// the scan reads the task memory one slot a cycle over its single read port, then
// a drain step lets the last read land, a commit step writes the winner back to
// memory and a report step loads the result word into the output register.
// Reset clears slot flags, counters, time and overflow; the task memory is not
// cleared, since only loaded slots can ever compete.
// A stalled result is held in the output register; a new request is still taken,
// and its result waits in the report stage until the register frees.

module preemptive_priority_scheduler #(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pps_req_if.sink   req_i,
  pps_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = $clog2(TASK_SLOTS);
  localparam int unsigned CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int unsigned SF_W  = pps_pkg::SLOT_FIELD_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);
  localparam pps_pkg::time_t TIME_MAX = pps_pkg::TIME_MAX;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_REPORT
  } state_e;

  state_e state_q;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic                 req_fire, load_fire, tick_fire, slot_ok;
  logic [31:0]          slot_ext;
  logic [IDX_W-1:0]     ld_idx;
  pps_pkg::time_t       ld_burst;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign slot_ext    = 32'(req_i.slot);
  assign slot_ok     = (slot_ext < TASK_SLOTS);
  assign ld_idx      = slot_ext[IDX_W-1:0];
  // drop loads to slots past the table
  assign load_fire   = req_fire && (req_i.req_type == pps_pkg::REQ_LOAD) && slot_ok;
  assign tick_fire   = req_fire && (req_i.req_type == pps_pkg::REQ_TICK);
  // a zero burst runs as one unit
  assign ld_burst    = (req_i.burst_time == '0) ? pps_pkg::time_t'(1) : req_i.burst_time;

  // ---------------------------------------------------------------------------
  // Slot flags, counters, time
  // ---------------------------------------------------------------------------
  logic [TASK_SLOTS-1:0] loaded_q, done_q;
  logic [CNT_W-1:0]      ld_cnt_q, fin_cnt_q;
  pps_pkg::time_t        time_q;
  logic                  ovf_q;

  // scan pipeline
  logic [IDX_W-1:0]      scan_idx_q, rd_idx_q;
  logic                  rd_vld_q;
  pps_pkg::task_t        rd_data;
  logic                  cand_vld;

  // winner of the scan
  logic                  best_found;
  logic [IDX_W-1:0]      best_idx;
  pps_pkg::task_t        best;

  // commit math
  pps_pkg::time_t        tend, rem_new, resp_new, tat;
  logic                  fin;
  logic                  commit_run;

  assign tend       = (time_q == TIME_MAX) ? TIME_MAX : time_q + pps_pkg::time_t'(1);
  assign rem_new    = best.remaining - pps_pkg::time_t'(1);
  assign fin        = (rem_new == '0);
  // record the response only on the first run
  assign resp_new   = best.started ? best.response : time_q - best.arrival;
  assign tat        = tend - best.arrival;
  assign commit_run = (state_q == ST_COMMIT) && best_found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q  <= '0;
      done_q    <= '0;
      ld_cnt_q  <= '0;
      fin_cnt_q <= '0;
      time_q    <= '0;
      ovf_q     <= 1'b0;
    end else begin
      if (load_fire) begin
        loaded_q[ld_idx] <= 1'b1;
        done_q[ld_idx]   <= 1'b0;
        if (loaded_q[ld_idx]) begin
          // reload of a finished task takes it off the finished tally
          if (done_q[ld_idx] && (fin_cnt_q != '0)) begin
            fin_cnt_q <= fin_cnt_q - CNT_W'(1);
          end
        end else begin
          ld_cnt_q <= ld_cnt_q + CNT_W'(1);
        end
      end
      if (commit_run && fin) begin
        done_q[best_idx] <= 1'b1;
        fin_cnt_q        <= fin_cnt_q + CNT_W'(1);
      end
      if (state_q == ST_COMMIT) begin
        time_q <= tend;
        if (time_q == TIME_MAX) begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Task memory: one write port shared by load and commit, one read port for scan
  // ---------------------------------------------------------------------------
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  pps_pkg::task_t   mem_wr_data;
  pps_pkg::task_t   ld_entry, upd_entry;

  always_comb begin
    ld_entry.arrival   = req_i.arrival_time;
    ld_entry.burst     = ld_burst;
    ld_entry.remaining = ld_burst;
    ld_entry.prio      = req_i.priority_req;
    ld_entry.response  = '0;
    ld_entry.started   = 1'b0;

    upd_entry           = best;
    upd_entry.remaining = rem_new;
    upd_entry.response  = resp_new;
    upd_entry.started   = 1'b1;
  end

  // load and commit never coincide: loads are only taken in idle
  assign mem_wr_en   = load_fire || commit_run;
  assign mem_wr_addr = load_fire ? ld_idx : best_idx;
  assign mem_wr_data = load_fire ? ld_entry : upd_entry;

  pps_task_mem #(
    .DEPTH (TASK_SLOTS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (state_q == ST_SCAN),
    .rd_addr_i (scan_idx_q),
    .rd_data_o (rd_data)
  );

  // a slot competes only if loaded and unfinished; arrival is checked in the picker
  assign cand_vld = rd_vld_q && loaded_q[rd_idx_q] && !done_q[rd_idx_q];

  pps_pick #(
    .IDX_W (IDX_W)
  ) u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (tick_fire),
    .cand_vld_i (cand_vld),
    .cand_idx_i (rd_idx_q),
    .cand_i     (rd_data),
    .now_i      (time_q),
    .found_o    (best_found),
    .idx_o      (best_idx),
    .best_o     (best)
  );

  // ---------------------------------------------------------------------------
  // Report stage: hold the committed tick until the output register frees
  // ---------------------------------------------------------------------------
  logic             rep_found_q, rep_fin_q;
  logic [IDX_W-1:0] rep_slot_q;
  pps_pkg::time_t   rep_t_q, rep_tend_q, rep_tat_q, rep_resp_q, rep_burst_q;
  pps_pkg::time_t   wt;
  logic             rep_fin;
  logic             out_vld_q, out_free, out_load;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_COMMIT) begin
      rep_found_q <= best_found;
      rep_fin_q   <= fin;
      rep_slot_q  <= best_idx;
      rep_t_q     <= time_q;
      rep_tend_q  <= tend;
      rep_tat_q   <= tat;
      rep_resp_q  <= resp_new;
      rep_burst_q <= best.burst;
    end
  end

  // saturated time can leave turnaround below burst: floor the wait at zero
  assign wt       = (rep_tat_q >= rep_burst_q) ? rep_tat_q - rep_burst_q : '0;
  assign rep_fin  = rep_found_q && rep_fin_q;
  assign out_free = !out_vld_q || rsp_o.ready;
  assign out_load = (state_q == ST_REPORT) && out_free;

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q               <= ST_IDLE;
      scan_idx_q            <= '0;
      rd_idx_q              <= '0;
      rd_vld_q              <= 1'b0;
      out_vld_q             <= 1'b0;
      rsp_o.running_valid   <= 1'b0;
      rsp_o.running_slot    <= '0;
      rsp_o.tick_time       <= '0;
      rsp_o.finished        <= 1'b0;
      rsp_o.completion_time <= '0;
      rsp_o.turnaround_time <= '0;
      rsp_o.waiting_time    <= '0;
      rsp_o.response_time   <= '0;
      rsp_o.all_done        <= 1'b0;
      rsp_o.time_overflow   <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == ST_SCAN);
      rd_idx_q <= scan_idx_q;

      // load a new word, or drop the current one once it is taken
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (tick_fire) begin
            scan_idx_q <= '0;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_idx_q == LAST_IDX) begin
            state_q <= ST_DRAIN;
          end else begin
            scan_idx_q <= scan_idx_q + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          state_q <= ST_REPORT;
        end
        ST_REPORT: begin
          if (out_load) begin
            rsp_o.running_valid   <= rep_found_q;
            rsp_o.running_slot    <= rep_found_q ? SF_W'(rep_slot_q) : '0;
            rsp_o.tick_time       <= rep_t_q;
            rsp_o.finished        <= rep_fin;
            rsp_o.completion_time <= rep_fin ? rep_tend_q : '0;
            rsp_o.turnaround_time <= rep_fin ? rep_tat_q : '0;
            rsp_o.waiting_time    <= rep_fin ? wt : '0;
            rsp_o.response_time   <= rep_fin ? rep_resp_q : '0;
            rsp_o.all_done        <= (fin_cnt_q == ld_cnt_q);
            rsp_o.time_overflow   <= ovf_q;
            state_q               <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid = out_vld_q;

`ifndef SYNTHESIS
  a_fin_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_cnt_q <= ld_cnt_q)
    else $error("finished count exceeds loaded count");

  a_done_is_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q & ~loaded_q) == '0)
    else $error("done flag set on an unloaded slot");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_DRAIN) |-> !mem_wr_en)
    else $error("task memory written during scan");

  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COMMIT |=>
      (time_q == $past(time_q) + pps_pkg::time_t'(1)) || (time_q == TIME_MAX))
    else $error("time did not advance by one tick");
`endif

endmodule

### design/pps_task_mem.sv
`timescale 1ns / 1ps

module pps_task_mem #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  pps_pkg::task_t           wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output pps_pkg::task_t           rd_data_o
);

  pps_pkg::task_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

### design/pps_pick.sv
`timescale 1ns / 1ps

module pps_pick #(
  parameter int unsigned IDX_W = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clr_i,
  input  logic                 cand_vld_i,
  input  logic [IDX_W-1:0]     cand_idx_i,
  input  pps_pkg::task_t       cand_i,
  input  pps_pkg::time_t       now_i,
  output logic                 found_o,
  output logic [IDX_W-1:0]     idx_o,
  output pps_pkg::task_t       best_o
);

  logic found_q;
  logic take;

  // strict compares keep the earlier (lower) slot on a full tie
  assign take = cand_vld_i && (cand_i.arrival <= now_i) &&
                (!found_q || (cand_i.prio < best_o.prio) ||
                 ((cand_i.prio == best_o.prio) && (cand_i.arrival < best_o.arrival)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (clr_i) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !clr_i) begin
      idx_o  <= cand_idx_i;
      best_o <= cand_i;
    end
  end

  assign found_o = found_q;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SLOTS       = 16;
  // One tick walks every slot, then drains, commits and reports.
  localparam int unsigned TICK_CYCLES = SLOTS + 4;
  localparam int unsigned MIX_WORDS   = 370;
  localparam int unsigned MAX_PRINTED = 40;

  typedef logic [pps_pkg::SLOT_FIELD_W-1:0] slot_t;

  // One request word as it goes over the request channel.
  typedef struct {
    logic            kind;
    slot_t           slot;
    pps_pkg::time_t  arrival;
    pps_pkg::time_t  burst;
    pps_pkg::prio_t  prio;
  } sched_req_t;

  // One report word as the block should return it for a tick.
  typedef struct {
    logic            ran;
    slot_t           slot;
    pps_pkg::time_t  start;
    logic            done;
    pps_pkg::time_t  completion;
    pps_pkg::time_t  turnaround;
    pps_pkg::time_t  waiting;
    pps_pkg::time_t  response;
    logic            all_done;
    logic            overflow;
  } tick_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pps_req_if req_if ();
  pps_rsp_if rsp_if ();

  preemptive_priority_scheduler #(
    .TASK_SLOTS(SLOTS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Requests waiting to go out, and tick reports still owed by the block.
  sched_req_t  pend_q[$];
  tick_word_t  tick_words_q[$];

  // Percent of cycles in which the sender holds off or the receiver stalls.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Set at a rising edge when the request word was taken there.
  logic req_took = 1'b0;

  // Time the generator expects the block to be at once all queued ticks ran;
  // it lets random arrivals land close to "now" so tasks actually get to run.
  pps_pkg::time_t gen_now = '0;

  // Shadow of the task table and the scheduler counters.
  pps_pkg::time_t tbl_arrival   [SLOTS];
  pps_pkg::time_t tbl_burst     [SLOTS];
  pps_pkg::time_t tbl_remaining [SLOTS];
  pps_pkg::time_t tbl_response  [SLOTS];
  pps_pkg::prio_t tbl_prio      [SLOTS];
  logic           tbl_loaded    [SLOTS] = '{default: 1'b0};
  logic           tbl_started   [SLOTS] = '{default: 1'b0};
  pps_pkg::time_t tbl_now        = '0;
  int unsigned    tbl_loaded_cnt = 0;
  int unsigned    tbl_done_cnt   = 0;
  logic           tbl_overflow   = 1'b0;

  int unsigned mismatch_cnt = 0;
  int unsigned word_cnt     = 0;
  int unsigned n_loads      = 0;
  int unsigned n_ticks      = 0;
  int unsigned n_idle       = 0;
  int unsigned n_completed  = 0;
  int unsigned n_overflow   = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or stops answering.
  initial begin
    #100_000_000;
    $display("timeout: %0d tick words still owed", tick_words_q.size());
    $display("tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTED) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("word %0d %s: got %0h, want %0h", word_cnt, name, got, want));
    end
  endtask

  // Load a slot: a zero burst counts as one unit, and reloading a finished
  // slot takes it back out of the finished count.
  task automatic table_load(sched_req_t r);
    pps_pkg::time_t b;
    b = (r.burst == '0) ? pps_pkg::time_t'(1) : r.burst;
    if (tbl_loaded[r.slot]) begin
      if (tbl_remaining[r.slot] == '0 && tbl_done_cnt > 0) tbl_done_cnt--;
    end else begin
      tbl_loaded[r.slot] = 1'b1;
      tbl_loaded_cnt++;
    end
    tbl_arrival[r.slot]   = r.arrival;
    tbl_burst[r.slot]     = b;
    tbl_remaining[r.slot] = b;
    tbl_prio[r.slot]      = r.prio;
    tbl_response[r.slot]  = '0;
    tbl_started[r.slot]   = 1'b0;
  endtask

  // Run one time unit: pick the most urgent ready task, earliest arrival on
  // a priority tie, lowest slot after that. Time sticks at its maximum.
  task automatic table_tick(output tick_word_t w);
    pps_pkg::time_t t;
    pps_pkg::time_t tend;
    pps_pkg::time_t tat;
    logic           found;
    slot_t          sel;
    pps_pkg::prio_t best_prio;
    pps_pkg::time_t best_arr;
    found     = 1'b0;
    sel       = '0;
    best_prio = '0;
    best_arr  = '0;
    t = tbl_now;
    if (t == pps_pkg::TIME_MAX) begin
      tend         = pps_pkg::TIME_MAX;
      tbl_overflow = 1'b1;
    end else begin
      tend = t + pps_pkg::time_t'(1);
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_loaded[i] || tbl_remaining[i] == '0 || tbl_arrival[i] > t) continue;
      if (!found || tbl_prio[i] < best_prio ||
          (tbl_prio[i] == best_prio && tbl_arrival[i] < best_arr)) begin
        found     = 1'b1;
        sel       = slot_t'(i);
        best_prio = tbl_prio[i];
        best_arr  = tbl_arrival[i];
      end
    end
    w = '{default: '0};
    w.start = t;
    if (found) begin
      w.ran  = 1'b1;
      w.slot = sel;
      if (!tbl_started[sel]) begin
        tbl_started[sel]  = 1'b1;
        tbl_response[sel] = t - tbl_arrival[sel];
      end
      tbl_remaining[sel]--;
      if (tbl_remaining[sel] == '0) begin
        tat = tend - tbl_arrival[sel];
        tbl_done_cnt++;
        w.done       = 1'b1;
        w.completion = tend;
        w.turnaround = tat;
        // Saturated time can leave turnaround below the burst: floor at zero.
        w.waiting    = (tat >= tbl_burst[sel]) ? tat - tbl_burst[sel] : '0;
        w.response   = tbl_response[sel];
      end
    end
    tbl_now    = tend;
    w.all_done = (tbl_done_cnt == tbl_loaded_cnt);
    w.overflow = tbl_overflow;
  endtask

  // Monitor: check report words first, then fold any accepted request into
  // the shadow table. A tick's report lags its request by a full scan, so the
  // order of the two within one edge never matters.
  always @(posedge clk_i) begin : monitor
    tick_word_t got;
    tick_word_t want;
    tick_word_t predicted;
    sched_req_t r;
    if (!rst_ni) begin
      req_took <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.ran        = rsp_if.running_valid;
        got.slot       = rsp_if.running_slot;
        got.start      = rsp_if.tick_time;
        got.done       = rsp_if.finished;
        got.completion = rsp_if.completion_time;
        got.turnaround = rsp_if.turnaround_time;
        got.waiting    = rsp_if.waiting_time;
        got.response   = rsp_if.response_time;
        got.all_done   = rsp_if.all_done;
        got.overflow   = rsp_if.time_overflow;
        if (tick_words_q.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with no tick pending", word_cnt));
        end else begin
          want = tick_words_q.pop_front();
          check_field("running_valid",   32'(got.ran),        32'(want.ran));
          check_field("running_slot",    32'(got.slot),       32'(want.slot));
          check_field("tick_time",       32'(got.start),      32'(want.start));
          check_field("finished",        32'(got.done),       32'(want.done));
          check_field("completion_time", 32'(got.completion), 32'(want.completion));
          check_field("turnaround_time", 32'(got.turnaround), 32'(want.turnaround));
          check_field("waiting_time",    32'(got.waiting),    32'(want.waiting));
          check_field("response_time",   32'(got.response),   32'(want.response));
          check_field("all_done",        32'(got.all_done),   32'(want.all_done));
          check_field("time_overflow",   32'(got.overflow),   32'(want.overflow));
          if (!want.ran) n_idle++;
          if (want.done) n_completed++;
          if (want.overflow) n_overflow++;
        end
        word_cnt++;
      end
      if (req_if.valid && req_if.ready) begin
        r.kind    = req_if.req_type;
        r.slot    = req_if.slot;
        r.arrival = req_if.arrival_time;
        r.burst   = req_if.burst_time;
        r.prio    = req_if.priority_req;
        if (r.kind == pps_pkg::REQ_LOAD) begin
          table_load(r);
          n_loads++;
        end else begin
          table_tick(predicted);
          tick_words_q = {tick_words_q, predicted};
          n_ticks++;
        end
      end
      req_took <= req_if.valid && req_if.ready;
    end
  end

  // Driver: retire the word taken at the last rising edge, hold a word that
  // is still waiting, otherwise offer the next one unless idling this cycle.
  always @(negedge clk_i) begin : driver
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      rsp_if.ready <= 1'b0;
    end else begin
      if (req_took) void'(pend_q.pop_front());
      if (!req_if.valid || req_took) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid        <= 1'b1;
          req_if.req_type     <= pend_q[0].kind;
          req_if.slot         <= pend_q[0].slot;
          req_if.arrival_time <= pend_q[0].arrival;
          req_if.burst_time   <= pend_q[0].burst;
          req_if.priority_req <= pend_q[0].prio;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_load(slot_t s, pps_pkg::time_t arr, pps_pkg::time_t burst,
                            pps_pkg::prio_t prio);
    sched_req_t r;
    r = '{kind: pps_pkg::REQ_LOAD, slot: s, arrival: arr, burst: burst, prio: prio};
    pend_q = {pend_q, r};
  endtask

  task automatic queue_tick();
    sched_req_t r;
    r = '{kind: pps_pkg::REQ_TICK, slot: '0, arrival: '0, burst: '0, prio: '0};
    pend_q = {pend_q, r};
    if (gen_now != pps_pkg::TIME_MAX) gen_now++;
  endtask

  // Random traffic: mostly ticks, with loads that arrive soon with short bursts and tied
  // priorities, so preemption and completions happen often, plus far-off
  // arrivals, zero and huge bursts and full-range priorities as noise.
  task automatic queue_mix(int unsigned n);
    int unsigned    roll;
    int unsigned    arr;
    pps_pkg::time_t burst;
    pps_pkg::prio_t prio;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(99) >= 28) begin
        queue_tick();
        continue;
      end
      roll = $urandom_range(99);
      if (roll < 70) begin
        arr = gen_now + $urandom_range(10);
        if (arr > pps_pkg::TIME_MAX) arr = pps_pkg::TIME_MAX;
      end else if (roll < 80) begin
        arr = $urandom_range(gen_now);
      end else if (roll < 90) begin
        arr = $urandom_range(pps_pkg::TIME_MAX);
      end else begin
        arr = $urandom_range(1) ? pps_pkg::TIME_MAX : 0;
      end
      roll = $urandom_range(99);
      if (roll < 70)      burst = pps_pkg::time_t'($urandom_range(8, 1));
      else if (roll < 80) burst = '0;
      else if (roll < 90) burst = pps_pkg::time_t'($urandom_range(100, 9));
      else                burst = pps_pkg::time_t'($urandom_range(pps_pkg::TIME_MAX));
      prio = ($urandom_range(99) < 60) ? pps_pkg::prio_t'($urandom_range(7))
                                       : pps_pkg::prio_t'($urandom_range(255));
      queue_load(slot_t'($urandom_range(SLOTS - 1)), pps_pkg::time_t'(arr), burst, prio);
    end
  endtask

  // Hold until every queued word is taken and every report has come back.
  task automatic drain();
    while (pend_q.size() != 0 || tick_words_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned idle_plan[4][2];
    idle_plan = '{'{0, 0}, '{75, 0}, '{0, 75}, '{28, 28}};
    req_if.valid        = 1'b0;
    req_if.req_type     = pps_pkg::REQ_TICK;
    req_if.slot         = '0;
    req_if.arrival_time = '0;
    req_if.burst_time   = '0;
    req_if.priority_req = '0;
    rsp_if.ready        = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening, no idling.
    queue_tick();                                   // empty table: idle, all done
    queue_load(4'd0,  16'd0, 16'd0, 8'd255);        // zero burst loads as one
    queue_load(4'd15, 16'd0, 16'd2, 8'd0);
    queue_load(4'd7,  16'd0, 16'd1, 8'd0);          // full tie: lower slot wins
    queue_tick();
    queue_tick();
    queue_load(4'd9,  16'd0, 16'd3, 8'd0);
    queue_load(4'd2,  gen_now, 16'd2, 8'd0);        // later arrival loses the tie
    queue_tick();
    queue_tick();
    queue_load(4'd7,  16'd0, 16'hFFFF, 8'd200);     // reload a finished slot
    queue_load(4'd9,  16'd0, 16'd1, 8'd0);          // reload a running slot
    queue_load(4'd14, pps_pkg::TIME_MAX, 16'hFFFF, 8'd255); // arrives only at saturation
    repeat (4) queue_tick();
    queue_load(4'd3,  gen_now, 16'd1, 8'd0);        // preempt the long task
    repeat (3) queue_tick();
    drain();

    // Random traffic under each handshake pressure mix; the pause between
    // mixes also lets every report come home before new words go out.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_plan[p][0];
      recv_stall_pct = idle_plan[p][1];
      queue_mix(MIX_WORDS);
      drain();
    end

    // Let any stray late word show up before closing out.
    repeat (3 * TICK_CYCLES) @(posedge clk_i);
    if (tick_words_q.size() != 0) begin
      report_mismatch($sformatf("%0d tick words never came out", tick_words_q.size()));
    end

    $display("Ran %0d loads and %0d ticks: %0d idle ticks, %0d completions, %0d overflow words",
             n_loads, n_ticks, n_idle, n_completed, n_overflow);
    $display("Covered four idle/stall mixes, each drained before the next; %0d mismatches",
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
